/* rtl/kil_pkg.sv */
// Shared types, token codes and keyword lookup for the keyword and identifier lexer.
`timescale 1ns / 1ps

package kil_pkg;

  // Longest keyword; only this many leading characters take part in the lookup.
  localparam int KwMaxLen = 10;

  // Entries in the queue between the scanner and the result side.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // Characters the scanner looks for.
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChLf    = 8'h0a;

  typedef enum logic [3:0] {
    KIND_IDENT    = 4'd0,
    KIND_IF       = 4'd1,
    KIND_ELSE     = 4'd2,
    KIND_TRUE     = 4'd3,
    KIND_FALSE    = 4'd4,
    KIND_CONV     = 4'd5,
    KIND_FN       = 4'd6,
    KIND_TASK     = 4'd7,
    KIND_APPLY    = 4'd8,
    KIND_NOT_WORD = 4'd9,
    KIND_END      = 4'd10
  } token_kind_e;

  // One result item.
  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  len;
    logic [7:0]  off;
  } result_t;

  // What one input item produces: one or two result items.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } pair_t;

  // Keyword lookup on the leading characters, first character in the top byte.
  function automatic token_kind_e keyword_kind(input logic [7:0] cnt,
                                               input logic [KwMaxLen*8-1:0] w);
    token_kind_e k;
    k = KIND_IDENT;
    if (cnt == 8'd2 && w[KwMaxLen*8-1 -: 16] == "if") k = KIND_IF;
    if (cnt == 8'd4 && w[KwMaxLen*8-1 -: 32] == "else") k = KIND_ELSE;
    if (cnt == 8'd4 && w[KwMaxLen*8-1 -: 32] == "true") k = KIND_TRUE;
    if (cnt == 8'd5 && w[KwMaxLen*8-1 -: 40] == "false") k = KIND_FALSE;
    if (cnt == 8'd10 && w[KwMaxLen*8-1 -: 80] == "convention") k = KIND_CONV;
    if (cnt == 8'd2 && w[KwMaxLen*8-1 -: 16] == "fn") k = KIND_FN;
    if (cnt == 8'd4 && w[KwMaxLen*8-1 -: 32] == "task") k = KIND_TASK;
    if (cnt == 8'd5 && w[KwMaxLen*8-1 -: 40] == "apply") k = KIND_APPLY;
    return k;
  endfunction

endpackage

/* rtl/kil_front.sv */
// Scanner: accepts one byte per cycle while the queue is not full, tracks comments and words, builds result pairs.
`timescale 1ns / 1ps

module kil_front #(
  parameter int WORD_STORE = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  input  logic [7:0]    text_byte_i,
  input  logic          end_of_text_i,
  input  logic          q_full_i,
  output logic          q_wr_o,
  output kil_pkg::pair_t q_entry_o
);
  import kil_pkg::*;

  localparam int IdxW = $clog2(WORD_STORE);

  localparam logic [2:0] ModeIdle  = 3'd0;
  localparam logic [2:0] ModeWord  = 3'd1;
  localparam logic [2:0] ModeSlash = 3'd2;
  localparam logic [2:0] ModeLine  = 3'd3;
  localparam logic [2:0] ModeBlock = 3'd4;
  localparam logic [2:0] ModeBstar = 3'd5;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
  endfunction

  function automatic logic is_start(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_continue(input logic [7:0] c);
    return is_start(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  logic [2:0]       mode_q, mode_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [7:0]       chars_q [WORD_STORE];
  logic             chr_we;
  logic [IdxW-1:0]  chr_addr;
  logic             accept;
  logic             at_end;
  logic [KwMaxLen*8-1:0] word_w;
  result_t          word_res, slash_res, byte_res, end_res;
  logic             idle_emit, idle_start;
  logic [2:0]       idle_mode;
  result_t          res0, res1;
  logic [1:0]       nres;

  assign accept = push && !q_full_i;
  assign at_end = end_of_text_i || text_byte_i == 8'h00;

  // Leading characters of the current word, packed for the keyword lookup.
  always_comb begin
    for (int i = 0; i < KwMaxLen; i++) begin
      word_w[(KwMaxLen-1-i)*8 +: 8] = chars_q[i];
    end
  end

  // Candidate result items.
  always_comb begin
    word_res  = '{kind: keyword_kind(cnt_q, word_w), len: cnt_q, off: 8'd0};
    slash_res = '{kind: KIND_NOT_WORD, len: 8'd0, off: ChSlash};
    byte_res  = '{kind: KIND_NOT_WORD, len: 8'd0, off: text_byte_i};
    end_res   = '{kind: KIND_END, len: 8'd0, off: 8'd0};
  end

  // How a byte is handled between tokens.
  always_comb begin
    idle_emit  = 1'b0;
    idle_start = 1'b0;
    idle_mode  = ModeIdle;
    if (is_blank(text_byte_i)) begin
      idle_mode = ModeIdle;
    end else if (text_byte_i == ChSlash) begin
      idle_mode = ModeSlash;
    end else if (is_start(text_byte_i)) begin
      idle_mode  = ModeWord;
      idle_start = 1'b1;
    end else begin
      idle_emit = 1'b1;
    end
  end

  // Next scan state and the results of this byte.
  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    chr_we   = 1'b0;
    chr_addr = '0;
    res0     = end_res;
    res1     = end_res;
    nres     = 2'd0;
    if (at_end) begin
      mode_d = ModeIdle;
      cnt_d  = 8'd0;
      nres   = 2'd1;
      if (mode_q == ModeWord) begin
        res0 = word_res;
        nres = 2'd2;
      end else if (mode_q == ModeSlash) begin
        res0 = slash_res;
        nres = 2'd2;
      end
    end else begin
      case (mode_q)
        ModeWord: begin
          if (is_continue(text_byte_i)) begin
            if (cnt_q < 8'(WORD_STORE)) begin
              chr_we   = 1'b1;
              chr_addr = cnt_q[IdxW-1:0];
            end
            if (cnt_q != 8'd255) cnt_d = cnt_q + 8'd1;
          end else begin
            res0   = word_res;
            res1   = byte_res;
            nres   = idle_emit ? 2'd2 : 2'd1;
            mode_d = idle_mode;
            cnt_d  = idle_start ? 8'd1 : 8'd0;
            chr_we = idle_start;
          end
        end
        ModeSlash: begin
          if (text_byte_i == ChSlash) begin
            mode_d = ModeLine;
          end else if (text_byte_i == ChStar) begin
            mode_d = ModeBlock;
          end else begin
            res0   = slash_res;
            res1   = byte_res;
            nres   = idle_emit ? 2'd2 : 2'd1;
            mode_d = idle_mode;
            cnt_d  = idle_start ? 8'd1 : cnt_q;
            chr_we = idle_start;
          end
        end
        ModeLine: begin
          if (text_byte_i == ChLf) mode_d = ModeIdle;
        end
        ModeBlock: begin
          if (text_byte_i == ChStar) mode_d = ModeBstar;
        end
        ModeBstar: begin
          if (text_byte_i == ChSlash) mode_d = ModeIdle;
          else if (text_byte_i != ChStar) mode_d = ModeBlock;
        end
        default: begin
          res0   = byte_res;
          nres   = idle_emit ? 2'd1 : 2'd0;
          mode_d = idle_mode;
          cnt_d  = idle_start ? 8'd1 : cnt_q;
          chr_we = idle_start;
        end
      endcase
    end
  end

  // Hand the results to the queue.
  assign q_wr_o           = accept && nres != 2'd0;
  assign q_entry_o.two    = nres == 2'd2;
  assign q_entry_o.first  = res0;
  assign q_entry_o.second = res1;

  // Scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      cnt_q  <= 8'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // Word character store.
  always_ff @(posedge clk_i) begin
    if (accept && chr_we) begin
      chars_q[chr_addr] <= text_byte_i;
    end
  end

  // An end of input always leaves the scanner idle with no pending word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && at_end |=> mode_q == ModeIdle && cnt_q == 8'd0)
    else $error("scanner not idle after end of input");

  // A second result of one byte is always a not_a_word or the end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr_o && q_entry_o.two |->
      q_entry_o.second.kind == KIND_END || q_entry_o.second.kind == KIND_NOT_WORD)
    else $error("unexpected second result");

endmodule

/* rtl/kil_queue.sv */
// Short queue of result pairs between the scanner and the result side.
`timescale 1ns / 1ps

module kil_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  kil_pkg::pair_t wr_entry_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           valid_o,
  output kil_pkg::pair_t head_o
);
  import kil_pkg::*;

  pair_t                store_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;
  logic                 do_rd;

  assign full_o  = count_q == (QueuePtrW+1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign head_o  = store_q[rd_ptr_q];
  assign do_rd   = rd_i && valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr_i && !do_rd) count_q <= count_q + 1'b1;
      else if (!wr_i && do_rd) count_q <= count_q - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_i) store_q[wr_ptr_q] <= wr_entry_i;
  end

  // The scanner never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i |-> !full_o)
    else $error("write into full queue");

endmodule

/* rtl/kil_back.sv */
// Result side: hands out the one or two results of each queued pair, one per pop.
`timescale 1ns / 1ps

module kil_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  kil_pkg::pair_t q_head_i,
  output logic           q_rd_o,
  input  logic           pop,
  output logic           empty,
  output logic [3:0]     token_kind_o,
  output logic [7:0]     word_length_o,
  output logic [7:0]     offending_byte_o,
  output logic           last_of_run_o
);
  import kil_pkg::*;

  logic    half_q;
  logic    take;
  result_t cur;

  assign empty            = !q_valid_i;
  assign take             = pop && q_valid_i;
  assign cur              = half_q ? q_head_i.second : q_head_i.first;
  assign token_kind_o     = cur.kind;
  assign word_length_o    = cur.len;
  assign offending_byte_o = cur.off;
  assign last_of_run_o    = half_q || !q_head_i.two;
  assign q_rd_o           = take && (half_q || !q_head_i.two);

  // Selects the second result of a pair once the first is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 1'b0;
    end else if (take) begin
      half_q <= q_head_i.two && !half_q;
    end
  end

  // The second half is only selected while a two-result pair waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> q_valid_i && q_head_i.two)
    else $error("second half selected without a pair");

endmodule

/* rtl/keyword_identifier_lexer.sv */
// Top level of the keyword and identifier lexer: scanner, result queue and result side.
// Throughput: one text byte accepted every cycle while the queue has room.
// Results of a byte are written into the queue and reach the result ports once earlier pairs are popped.
// Results leave one per pop; a byte that causes two results takes two pops.
// The queue holds four pairs; full is raised only when all four wait.
// Reset (asynchronous, active low) empties the queue and leaves the scanner idle.
`timescale 1ns / 1ps

module keyword_identifier_lexer #(
  parameter int WORD_STORE = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       pop,
  output logic       empty,
  output logic [3:0] token_kind_o,
  output logic [7:0] word_length_o,
  output logic [7:0] offending_byte_o,
  output logic       last_of_run_o
);
  import kil_pkg::*;

  logic  q_wr, q_full, q_rd, q_valid;
  pair_t q_entry, q_head;

  assign full = q_full;

  // Scanner.
  kil_front #(
    .WORD_STORE(WORD_STORE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .q_full_i     (q_full),
    .q_wr_o       (q_wr),
    .q_entry_o    (q_entry)
  );

  // Pair queue.
  kil_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_entry_i(q_entry),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .valid_o   (q_valid),
    .head_o    (q_head)
  );

  // Result side.
  kil_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (q_head),
    .q_rd_o          (q_rd),
    .pop             (pop),
    .empty           (empty),
    .token_kind_o    (token_kind_o),
    .word_length_o   (word_length_o),
    .offending_byte_o(offending_byte_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule
